// File: src/kpirq_pkg.sv
// Package for the keypad register block: field widths, operation and register codes.
package kpirq_pkg;

  localparam int KeyBits = 10;
  localparam int PressBits = 13;

  localparam logic [9:0] KeyBitsMask = 10'h3FF;
  localparam logic [7:0] ExtBase = 8'h34;
  localparam logic [7:0] ExtPenBit = 8'h40;
  localparam logic [7:0] ExtReset = 8'h7F;

  // Operation codes, carried in tuser
  localparam logic [1:0] OpKeyUpdate = 2'd0;
  localparam logic [1:0] OpByteRead = 2'd1;
  localparam logic [1:0] OpByteWrite = 2'd2;
  localparam logic [1:0] OpHalfWrite = 2'd3;

  // Register select codes
  localparam logic [1:0] SelKeyInput = 2'd0;
  localparam logic [1:0] SelExtInput = 2'd1;
  localparam logic [1:0] SelCtrlCpu7 = 2'd2;
  localparam logic [1:0] SelCtrlCpu9 = 2'd3;

  typedef logic [KeyBits-1:0] key_t;

  typedef struct packed {
    key_t mask;
    logic enable;
    logic all_mode;
  } ctrl_t;

  function automatic logic ctrl_check(ctrl_t c, key_t key_reg);
    key_t pressed;
    pressed = ~key_reg & KeyBitsMask;
    if (!c.enable) return 1'b0;
    if (c.all_mode) return c.mask == pressed;
    return (c.mask & pressed) != '0;
  endfunction

endpackage

// File: src/keypad_register_block_irq_unit.sv
// Top level: keypad input registers with two keypad interrupt controllers.
// Keypad register block with one interrupt controller for each CPU (cpu7, cpu9).
// Each transfer on the slave side is one operation: a key update, a byte read, a
// byte write or a halfword write; each gives exactly one transfer on the master
// side with the read byte and one interrupt pulse bit per CPU. The whole operation
// is done in the cycle it is accepted (state updates at that edge, the result is
// registered), so one item is taken per clock; s_tready drops only while a result
// sits in the output register and m_tready is low.
module keypad_register_block_irq_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: [12:0] keys_pressed, [13] byte_offset, [29:14] write_data, [31:30] zero
  input  logic [31:0] s_tdata,
  // s_tuser: [1:0] mode, [3:2] register_select
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: [7:0] read_data, [8] irq_cpu7, [9] irq_cpu9, [15:10] zero
  output logic [15:0] m_tdata
);
  import kpirq_pkg::*;

  logic [PressBits-1:0] keys;
  logic                 off;
  logic [15:0]          wdata;
  logic [1:0]           op;
  logic [1:0]           sel;

  key_t       key_register;
  key_t       key_next;
  logic [7:0] ext_key_register;
  logic [7:0] ext_next;
  ctrl_t      ctrl [2];
  ctrl_t      ctrl_next [2];

  logic       accept;
  logic       is_write;
  logic       ctrl_sel;
  logic [7:0] rd;
  logic [1:0] irq;
  logic [7:0] m_byte;
  logic [1:0] m_irq;

  assign keys  = s_tdata[12:0];
  assign off   = s_tdata[13];
  assign wdata = s_tdata[29:14];
  assign op    = s_tuser[1:0];
  assign sel   = s_tuser[3:2];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_write = (op == OpByteWrite || op == OpHalfWrite) &&
                    (sel == SelCtrlCpu7 || sel == SelCtrlCpu9);
  assign ctrl_sel = sel[0];

  always_comb begin
    key_next = key_register;
    ext_next = ext_key_register;
    ctrl_next[0] = ctrl[0];
    ctrl_next[1] = ctrl[1];
    if (op == OpKeyUpdate) begin
      key_next = ~keys[KeyBits-1:0];
      ext_next = ExtBase;
      if (!keys[10]) ext_next[0] = 1'b1;
      if (!keys[11]) ext_next[1] = 1'b1;
      if (!keys[12]) ext_next = ext_next | ExtPenBit;
    end
    if (is_write) begin
      if (op == OpHalfWrite) begin
        ctrl_next[ctrl_sel].mask     = wdata[9:0];
        ctrl_next[ctrl_sel].enable   = wdata[14];
        ctrl_next[ctrl_sel].all_mode = wdata[15];
      end else if (!off) begin
        ctrl_next[ctrl_sel].mask[7:0] = wdata[7:0];
      end else begin
        ctrl_next[ctrl_sel].mask[9:8] = wdata[1:0];
        ctrl_next[ctrl_sel].enable    = wdata[6];
        ctrl_next[ctrl_sel].all_mode  = wdata[7];
      end
    end
  end

  // read path sees the state before this item
  always_comb begin
    rd = '0;
    if (op == OpByteRead) begin
      unique case (sel)
        SelKeyInput: rd = off ? {6'd0, key_register[9:8]} : key_register[7:0];
        SelExtInput: rd = off ? 8'd0 : ext_key_register;
        SelCtrlCpu7, SelCtrlCpu9: begin
          rd = off ? {ctrl[ctrl_sel].all_mode, ctrl[ctrl_sel].enable, 4'd0,
                      ctrl[ctrl_sel].mask[9:8]}
                   : ctrl[ctrl_sel].mask[7:0];
        end
        default: rd = '0;
      endcase
    end
  end

  // interrupt check sees the state after this item
  always_comb begin
    irq = '0;
    if (op == OpKeyUpdate) begin
      irq[0] = ctrl_check(ctrl_next[0], key_next);
      irq[1] = ctrl_check(ctrl_next[1], key_next);
    end else if (is_write) begin
      irq[ctrl_sel] = ctrl_check(ctrl_next[ctrl_sel], key_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_register     <= '0;
      ext_key_register <= ExtReset;
      ctrl[0]          <= '0;
      ctrl[1]          <= '0;
    end else if (accept) begin
      key_register     <= key_next;
      ext_key_register <= ext_next;
      ctrl[0]          <= ctrl_next[0];
      ctrl[1]          <= ctrl_next[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_byte <= rd;
      m_irq  <= irq;
    end
  end

  assign m_tdata = {6'd0, m_irq, m_byte};

endmodule
